>>> hw/rtl/ocfd_pkg.sv
// ----------------------------------------------------------------------------
// Output command frame decoder package
// Shared constants and controller/datapath handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package ocfd_pkg;

   localparam int BYTE_W = 8;
   localparam int POS_W  = 6;

   localparam logic [BYTE_W-1:0] TYPE_SINGLE = 8'h53;
   localparam logic [BYTE_W-1:0] TYPE_BANK   = 8'h4F;

   typedef struct packed {
      logic accept;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic frame_emit;
      logic last_emit;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/ocfd_datapath.sv
// ----------------------------------------------------------------------------
// Output command frame decoder datapath
// Byte counter, running XOR check, frame head store and update generator.
// ----------------------------------------------------------------------------
`default_nettype none

module ocfd_datapath #(
   parameter int FRAME_BYTES = 40,
   parameter int BANK_SIZE   = 7
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ocfd_pkg::cmd_type         cmd,
   output ocfd_pkg::status_type           status,
   input  wire logic [ocfd_pkg::BYTE_W-1:0] rx_byte,
   input  wire logic                      frame_start,
   output logic [ocfd_pkg::BYTE_W-1:0]    output_id,
   output logic [ocfd_pkg::BYTE_W-1:0]    level,
   output logic                           last_of_run
);
   import ocfd_pkg::*;

   localparam int HEAD_DEPTH = 3 + BANK_SIZE;
   localparam int HEAD_W     = $clog2(HEAD_DEPTH);
   localparam int IDX_W      = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;

   logic [POS_W-1:0]  pos_ff, pos_in, pos_eff;
   logic [BYTE_W-1:0] xor_ff, xor_in, xor_eff;
   logic [BYTE_W-1:0] head_ff [HEAD_DEPTH];
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0] id_ff, id_in;
   logic              single_ff, single_in;
   logic              frame_end;
   logic              frame_good;
   logic [HEAD_W-1:0] lvl_addr;

   always_comb begin
      pos_eff = frame_start ? '0 : pos_ff;
      xor_eff = frame_start ? '0 : xor_ff;
      if ({1'b0, pos_eff} >= (POS_W+1)'(FRAME_BYTES)) begin
         pos_eff = '0;
         xor_eff = '0;
      end
      frame_end  = (pos_eff == POS_W'(FRAME_BYTES - 1));
      frame_good = frame_end && (xor_eff == rx_byte);
      status.frame_emit = frame_good &&
         ((head_ff[0] == TYPE_SINGLE) ||
          ((head_ff[0] == TYPE_BANK) && (head_ff[1] != '0)));
      status.last_emit = single_ff || (idx_ff == IDX_W'(BANK_SIZE - 1));
   end

   always_comb begin
      pos_in    = pos_ff;
      xor_in    = xor_ff;
      idx_in    = idx_ff;
      id_in     = id_ff;
      single_in = single_ff;
      if (cmd.accept) begin
         if (frame_end) begin
            pos_in = '0;
            xor_in = '0;
         end else begin
            pos_in = pos_eff + POS_W'(1);
            xor_in = xor_eff ^ rx_byte;
         end
         if (status.frame_emit) begin
            single_in = (head_ff[0] == TYPE_SINGLE);
            idx_in    = '0;
            id_in     = (head_ff[0] == TYPE_SINGLE) ? head_ff[1]
                        : BYTE_W'(head_ff[2] * BYTE_W'(BANK_SIZE));
         end
      end else if (cmd.step) begin
         idx_in = idx_ff + IDX_W'(1);
         id_in  = id_ff + BYTE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         xor_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         xor_ff <= xor_in;
      end
      idx_ff    <= idx_in;
      id_ff     <= id_in;
      single_ff <= single_in;
      if (cmd.accept && (pos_eff < POS_W'(HEAD_DEPTH))) begin
         head_ff[pos_eff[HEAD_W-1:0]] <= rx_byte;
      end
   end

   assign lvl_addr    = HEAD_W'(3) + HEAD_W'(idx_ff);
   assign output_id   = id_ff;
   assign level       = single_ff ? head_ff[2] : head_ff[lvl_addr];
   assign last_of_run = status.last_emit;

endmodule

`default_nettype wire

>>> hw/rtl/ocfd_controller.sv
// ----------------------------------------------------------------------------
// Output command frame decoder controller
// Alternates between taking frame bytes and sending the updates of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ocfd_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output ocfd_pkg::cmd_type         cmd,
   input  wire ocfd_pkg::status_type status
);
   import ocfd_pkg::*;

   typedef enum logic {
      ST_RECEIVE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      tready_ff;
   logic      tvalid_ff;

   assign cmd.accept = req_tvalid && tready_ff;
   assign cmd.step   = tvalid_ff && rsp_tready;
   assign req_tready = tready_ff;
   assign rsp_tvalid = tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_RECEIVE;
         tready_ff <= 1'b1;
         tvalid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_RECEIVE: begin
               if (cmd.accept && status.frame_emit) begin
                  state_ff  <= ST_EMIT;
                  tready_ff <= 1'b0;
                  tvalid_ff <= 1'b1;
               end
            end
            ST_EMIT: begin
               if (cmd.step && status.last_emit) begin
                  state_ff  <= ST_RECEIVE;
                  tready_ff <= 1'b1;
                  tvalid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff  <= ST_RECEIVE;
               tready_ff <= 1'b1;
               tvalid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/output_command_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// Output command frame decoder core
// Checks fixed-length command frames and turns them into output updates.
// ----------------------------------------------------------------------------
// Latency: the first update of a frame is valid the cycle after its last byte.
// Throughput: one byte per cycle while receiving; the update sequencer then
// holds off requests for 1 (single) or BANK_SIZE (bank) accepted updates.
// Reset: synchronous; clears the byte count, XOR and state machine only.
`default_nettype none

module output_command_frame_decoder_core #(
   parameter int FRAME_BYTES = 40,
   parameter int BANK_SIZE   = 7
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] rx_byte
   input  wire logic        req_tuser,  // [0] frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // [7:0] output_id, [15:8] level
   output logic             rsp_tlast   // last_of_run
);
   import ocfd_pkg::*;

   cmd_type           cmd;
   status_type        status;
   logic [BYTE_W-1:0] output_id;
   logic [BYTE_W-1:0] level;

   ocfd_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   ocfd_datapath #(
      .FRAME_BYTES (FRAME_BYTES),
      .BANK_SIZE   (BANK_SIZE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .rx_byte     (req_tdata),
      .frame_start (req_tuser),
      .output_id   (output_id),
      .level       (level),
      .last_of_run (rsp_tlast)
   );

   assign rsp_tdata = {level, output_id};

endmodule

`default_nettype wire

>>> hw/rtl/ocfd_checker.sv
// ----------------------------------------------------------------------------
// Output command frame decoder checker
// Port-level properties of the decoder core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ocfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Update valid right after reset.");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("Requests taken while updates are pending.");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid && req_tready))
      else $error("Decoder did not return to receiving after the last update.");

   a_run_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("Update run ended without a last marker.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("Stalled update changed.");

endmodule

bind output_command_frame_decoder_core ocfd_checker u_ocfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
